[sv/color_matrix_transform_unit_macros.svh]
// assertion macros for the color matrix transform unit
`ifndef COLOR_MATRIX_TRANSFORM_UNIT_MACROS_SVH
`define COLOR_MATRIX_TRANSFORM_UNIT_MACROS_SVH

// antecedent in this cycle, consequent in the next
`define CMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("color matrix transform: next-cycle check failed");

// antecedent and consequent in the same cycle
`define CMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("color matrix transform: same-cycle check failed");

`endif

[sv/cmt_pkg.sv]
// shared constants and types for the color matrix transform unit
package cmt_pkg;

  localparam int PIX_W     = 8;
  localparam int ROW_W     = 64;
  localparam int SLOT_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CHAN_MAX  = 255;
  localparam int NSTAGE    = 5;

  // slot positions inside a row register
  localparam int SLOT_OFFSET = 0;
  localparam int SLOT_RED    = 1;
  localparam int SLOT_GREEN  = 2;
  localparam int SLOT_BLUE   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RED_ROW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_ROW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_ROW  = 2'd2;

  // identity matrix, zero offsets
  localparam logic [ROW_W-1:0] RED_ROW_RESET   = 64'h0000_0000_00FF_0000;
  localparam logic [ROW_W-1:0] GREEN_ROW_RESET = 64'h0000_00FF_0000_0000;
  localparam logic [ROW_W-1:0] BLUE_ROW_RESET  = 64'h00FF_0000_0000_0000;

  // per-stage load enables for the channel datapath
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } cmt_adv_t;

endpackage

[sv/cmt_ifs.sv]
// valid/ready channel interfaces for pixels in and results out
interface cmt_in_if;
  logic                      valid;
  logic                      ready;
  logic [cmt_pkg::PIX_W-1:0] red_in;
  logic [cmt_pkg::PIX_W-1:0] green_in;
  logic [cmt_pkg::PIX_W-1:0] blue_in;
  logic [cmt_pkg::PIX_W-1:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface cmt_out_if;
  logic                      valid;
  logic                      ready;
  logic [cmt_pkg::PIX_W-1:0] red_out;
  logic [cmt_pkg::PIX_W-1:0] green_out;
  logic [cmt_pkg::PIX_W-1:0] blue_out;
  logic [cmt_pkg::PIX_W-1:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

[sv/cmt_channel.sv]
// one output channel: dot product, divide by 255 toward zero, offset and clamp
module cmt_channel #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                          clk,
  input  cmt_pkg::cmt_adv_t             adv,
  input  logic [cmt_pkg::ROW_W-1:0]     row,
  input  logic [cmt_pkg::PIX_W-1:0]     red,
  input  logic [cmt_pkg::PIX_W-1:0]     green,
  input  logic [cmt_pkg::PIX_W-1:0]     blue,
  output logic [cmt_pkg::PIX_W-1:0]     chan_out
);

  localparam int PW   = COEF_WIDTH + cmt_pkg::PIX_W + 1;  // one product
  localparam int DW   = PW + 1;                           // dot product, signed
  localparam int MW   = PW;                               // dot magnitude
  localparam int S    = MW + 1;                           // reciprocal shift
  localparam int RW   = S - 7;
  localparam int QW   = MW - 7;
  localparam int SUMW = QW + 3;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << S) / 64'd255);

  logic signed [COEF_WIDTH-1:0] off_c, red_c, green_c, blue_c;
  logic signed [cmt_pkg::PIX_W:0] red_s, green_s, blue_s;

  assign off_c   = row[cmt_pkg::SLOT_W*cmt_pkg::SLOT_OFFSET +: COEF_WIDTH];
  assign red_c   = row[cmt_pkg::SLOT_W*cmt_pkg::SLOT_RED    +: COEF_WIDTH];
  assign green_c = row[cmt_pkg::SLOT_W*cmt_pkg::SLOT_GREEN  +: COEF_WIDTH];
  assign blue_c  = row[cmt_pkg::SLOT_W*cmt_pkg::SLOT_BLUE   +: COEF_WIDTH];
  assign red_s   = $signed({1'b0, red});
  assign green_s = $signed({1'b0, green});
  assign blue_s  = $signed({1'b0, blue});

  // stage 2: products
  logic signed [PW-1:0] prod_r, prod_g, prod_b;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      prod_r <= PW'(red_c * red_s);
      prod_g <= PW'(green_c * green_s);
      prod_b <= PW'(blue_c * blue_s);
    end
  end

  // stage 3: dot product as sign and magnitude
  logic signed [DW-1:0] dot;
  logic signed [DW-1:0] dot_abs;
  logic [MW-1:0]        mag3;
  logic                 neg3;

  assign dot     = DW'(prod_r) + DW'(prod_g) + DW'(prod_b);
  assign dot_abs = dot[DW-1] ? -dot : dot;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      mag3 <= dot_abs[MW-1:0];
      neg3 <= dot[DW-1];
    end
  end

  // stage 4: quotient estimate by reciprocal, low by at most one
  logic [MW+RW-1:0] prod_q;
  logic [QW-1:0]    q4;
  logic [MW-1:0]    mag4;
  logic             neg4;

  assign prod_q = (MW+RW)'(mag3) * (MW+RW)'(RECIP);

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      q4   <= prod_q[S +: QW];
      mag4 <= mag3;
      neg4 <= neg3;
    end
  end

  // stage 5: correct quotient, restore sign, add offset, clamp
  logic [MW:0]            q255;
  logic [MW:0]            rem;
  logic [QW:0]            qfix;
  logic signed [SUMW-1:0] qmag;
  logic signed [SUMW-1:0] qsig;
  logic signed [SUMW-1:0] sum;
  logic [cmt_pkg::PIX_W-1:0] chan_next;

  assign q255 = {q4, 8'd0} - (MW+1)'(q4);
  assign rem  = (MW+1)'(mag4) - q255;
  assign qfix = (QW+1)'(q4) + (QW+1)'(rem >= (MW+1)'(cmt_pkg::CHAN_MAX));
  assign qmag = $signed(SUMW'(qfix));
  assign qsig = neg4 ? -qmag : qmag;
  assign sum  = SUMW'(off_c) + qsig;

  always_comb begin
    if (sum < 0) begin
      chan_next = '0;
    end else if (sum > $signed(SUMW'(cmt_pkg::CHAN_MAX))) begin
      chan_next = cmt_pkg::PIX_W'(cmt_pkg::CHAN_MAX);
    end else begin
      chan_next = sum[cmt_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      chan_out <= chan_next;
    end
  end

endmodule

[sv/color_matrix_transform_unit.sv]
// top level: 3x3 color matrix with offsets, divide by 255, clamp, alpha pass-through
// throughput: one pixel per cycle unless the result side stalls, set by the
// five-stage pipeline of each channel (input register, multiply, dot sum,
// reciprocal multiply, correct/offset/clamp)
// a stall on the result side holds each full stage; empty stages still fill
// reset clears all valid bits and loads the identity matrix with zero offsets
`include "color_matrix_transform_unit_macros.svh"

module color_matrix_transform_unit #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cmt_pkg::ROW_W-1:0]         cfg_data,
  cmt_in_if.sink                            pixel,
  cmt_out_if.source                         result
);

  localparam int NS = cmt_pkg::NSTAGE;

  logic [cmt_pkg::ROW_W-1:0] red_row, green_row, blue_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_row   <= cmt_pkg::RED_ROW_RESET;
      green_row <= cmt_pkg::GREEN_ROW_RESET;
      blue_row  <= cmt_pkg::BLUE_ROW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cmt_pkg::REG_RED_ROW:   red_row   <= cfg_data;
        cmt_pkg::REG_GREEN_ROW: green_row <= cfg_data;
        cmt_pkg::REG_BLUE_ROW:  blue_row  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when it is empty or its successor moves
  logic [NS-1:0] vld;
  logic [NS-1:0] adv;
  cmt_pkg::cmt_adv_t adv_s;

  always_comb begin
    adv[NS-1] = !vld[NS-1] || result.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign adv_s = '{s2: adv[1], s3: adv[2], s4: adv[3], s5: adv[4]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= pixel.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign pixel.ready  = adv[0];
  assign result.valid = vld[NS-1];

  // stage 1 input register and alpha delay line
  logic [cmt_pkg::PIX_W-1:0] red1, green1, blue1;
  logic [cmt_pkg::PIX_W-1:0] alpha_pipe [NS];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      red1          <= pixel.red_in;
      green1        <= pixel.green_in;
      blue1         <= pixel.blue_in;
      alpha_pipe[0] <= pixel.alpha_in;
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        alpha_pipe[k] <= alpha_pipe[k-1];
      end
    end
  end

  assign result.alpha_out = alpha_pipe[NS-1];

  cmt_channel #(.COEF_WIDTH(COEF_WIDTH)) u_red (
    .clk      (clk),
    .adv      (adv_s),
    .row      (red_row),
    .red      (red1),
    .green    (green1),
    .blue     (blue1),
    .chan_out (result.red_out)
  );

  cmt_channel #(.COEF_WIDTH(COEF_WIDTH)) u_green (
    .clk      (clk),
    .adv      (adv_s),
    .row      (green_row),
    .red      (red1),
    .green    (green1),
    .blue     (blue1),
    .chan_out (result.green_out)
  );

  cmt_channel #(.COEF_WIDTH(COEF_WIDTH)) u_blue (
    .clk      (clk),
    .adv      (adv_s),
    .row      (blue_row),
    .red      (red1),
    .green    (green1),
    .blue     (blue1),
    .chan_out (result.blue_out)
  );

  // a transaction always lands in the input stage
  `CMT_ASSERT_NEXT(a_accept_fills_input, pixel.valid && pixel.ready, vld[0])
  // a moving product stage never drops its item
  `CMT_ASSERT_NEXT(a_stage_moves, vld[1] && adv[2], vld[2])
  // pipeline comes out of reset empty
  `CMT_ASSERT_SAME(a_empty_after_reset, $past(rst), vld == '0)

endmodule

[test/color_matrix_transform_unit_test.sv]
// testbench for the color matrix transform unit: directed and random pixels and matrices, self-checking
`timescale 1ns / 100ps

module color_matrix_transform_unit_test;

  localparam int COEF_W = 16;
  localparam int LIMIT_NS = 1_000_000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 100;
  localparam int REPORT_MAX = 10;
  // index past the last row register; writes there must be dropped
  localparam logic [cmt_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [cmt_pkg::PIX_W-1:0] red;
    logic [cmt_pkg::PIX_W-1:0] green;
    logic [cmt_pkg::PIX_W-1:0] blue;
    logic [cmt_pkg::PIX_W-1:0] alpha;
  } rgba_t;

  typedef enum int {ROWS_SMALL, ROWS_MAX_POS, ROWS_MAX_NEG, ROWS_ALL_ONES, ROWS_RANDOM} row_kind_t;

  class matrix_check;
    logic [cmt_pkg::ROW_W-1:0] red_row;
    logic [cmt_pkg::ROW_W-1:0] green_row;
    logic [cmt_pkg::ROW_W-1:0] blue_row;
    rgba_t pending_pixels[$];
    int errors;

    function new();
      red_row = cmt_pkg::RED_ROW_RESET;
      green_row = cmt_pkg::GREEN_ROW_RESET;
      blue_row = cmt_pkg::BLUE_ROW_RESET;
      errors = 0;
    endfunction

    function void write_row(logic [cmt_pkg::CFG_IDX_W-1:0] idx,
                            logic [cmt_pkg::ROW_W-1:0] data);
      case (idx)
        cmt_pkg::REG_RED_ROW: red_row = data;
        cmt_pkg::REG_GREEN_ROW: green_row = data;
        cmt_pkg::REG_BLUE_ROW: blue_row = data;
        default: ;
      endcase
    endfunction

    // low COEF_W bits of a slot, two's complement
    function int coef(logic [cmt_pkg::ROW_W-1:0] row, int slot);
      logic [cmt_pkg::SLOT_W-1:0] raw;
      logic [COEF_W-1:0] low;
      raw = row[slot*cmt_pkg::SLOT_W +: cmt_pkg::SLOT_W];
      low = raw[COEF_W-1:0];
      return int'($signed(low));
    endfunction

    function logic [cmt_pkg::PIX_W-1:0] mix_channel(logic [cmt_pkg::ROW_W-1:0] row, rgba_t p);
      int dot;
      int level;
      dot = coef(row, cmt_pkg::SLOT_RED) * int'(p.red)
          + coef(row, cmt_pkg::SLOT_GREEN) * int'(p.green)
          + coef(row, cmt_pkg::SLOT_BLUE) * int'(p.blue);
      // int division truncates toward zero
      level = coef(row, cmt_pkg::SLOT_OFFSET) + dot / cmt_pkg::CHAN_MAX;
      if (level < 0) level = 0;
      if (level > cmt_pkg::CHAN_MAX) level = cmt_pkg::CHAN_MAX;
      return level[cmt_pkg::PIX_W-1:0];
    endfunction

    function rgba_t transform_pixel(rgba_t p);
      rgba_t q;
      q.red = mix_channel(red_row, p);
      q.green = mix_channel(green_row, p);
      q.blue = mix_channel(blue_row, p);
      q.alpha = p.alpha;
      return q;
    endfunction

    function void note_pixel(rgba_t p);
      pending_pixels.push_back(transform_pixel(p));
    endfunction

    function void check_result(rgba_t got);
      rgba_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result r=%0d g=%0d b=%0d a=%0d",
                   got.red, got.green, got.blue, got.alpha);
        return;
      end
      want = pending_pixels.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                   want.red, want.green, want.blue, want.alpha,
                   got.red, got.green, got.blue, got.alpha);
      end
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [cmt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cmt_pkg::ROW_W-1:0] cfg_data;

  cmt_in_if pixel_if();
  cmt_out_if result_if();

  color_matrix_transform_unit #(.COEF_WIDTH(COEF_W)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel(pixel_if),
    .result(result_if)
  );

  matrix_check mcheck = new();
  bit quiet;
  int hold_request;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [cmt_pkg::PIX_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return '1;
    return cmt_pkg::PIX_W'($urandom_range(0, cmt_pkg::CHAN_MAX));
  endfunction

  function automatic logic [cmt_pkg::SLOT_W-1:0] pick_signed(int span);
    return cmt_pkg::SLOT_W'($urandom_range(0, 2 * span)) - cmt_pkg::SLOT_W'(span);
  endfunction

  function automatic logic [cmt_pkg::ROW_W-1:0] make_row(row_kind_t kind);
    case (kind)
      ROWS_MAX_POS: return {4{16'h7FFF}};
      ROWS_MAX_NEG: return {4{16'h8000}};
      ROWS_ALL_ONES: return '1;
      ROWS_RANDOM: return {$urandom, $urandom};
      default: return {pick_signed(600), pick_signed(600), pick_signed(600), pick_signed(300)};
    endcase
  endfunction

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(logic [cmt_pkg::CFG_IDX_W-1:0] idx,
                           logic [cmt_pkg::ROW_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    mcheck.write_row(idx, data);
    @(posedge clk);
  endtask

  task automatic load_rows(logic [cmt_pkg::ROW_W-1:0] r_row, logic [cmt_pkg::ROW_W-1:0] g_row,
                           logic [cmt_pkg::ROW_W-1:0] b_row, bit stray_write);
    write_reg(cmt_pkg::REG_RED_ROW, r_row);
    write_reg(cmt_pkg::REG_GREEN_ROW, g_row);
    write_reg(cmt_pkg::REG_BLUE_ROW, b_row);
    if (stray_write) write_reg(REG_NONE, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // called at a rising edge; returns at the edge that takes the transaction
  task automatic send_pixel(rgba_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_if.valid <= 1'b1;
    pixel_if.red_in <= p.red;
    pixel_if.green_in <= p.green;
    pixel_if.blue_in <= p.blue;
    pixel_if.alpha_in <= p.alpha;
    do @(negedge clk); while (!pixel_if.ready);
    mcheck.note_pixel(p);
    @(posedge clk);
  endtask

  task automatic send_random(int count);
    rgba_t p;
    repeat (count) begin
      p.red = pick_level();
      p.green = pick_level();
      p.blue = pick_level();
      p.alpha = pick_level();
      send_pixel(p);
    end
  endtask

  task automatic drain();
    pixel_if.valid <= 1'b0;
    while (mcheck.pending() != 0) @(posedge clk);
    repeat (cmt_pkg::NSTAGE + 2) @(posedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    result_if.ready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
      @(negedge clk);
      if (result_if.valid && result_if.ready)
        mcheck.check_result({result_if.red_out, result_if.green_out,
                             result_if.blue_out, result_if.alpha_out});
    end
  end

  initial begin
    row_kind_t kinds[7];
    kinds = '{ROWS_SMALL, ROWS_MAX_POS, ROWS_SMALL, ROWS_MAX_NEG,
              ROWS_RANDOM, ROWS_ALL_ONES, ROWS_SMALL};
    quiet = 1'b0;
    hold_request = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixel_if.valid = 1'b0;
    pixel_if.red_in = '0;
    pixel_if.green_in = '0;
    pixel_if.blue_in = '0;
    pixel_if.alpha_in = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity matrix straight out of reset
    send_pixel('{8'h00, 8'h00, 8'h00, 8'h00});
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel('{8'h55, 8'hAA, 8'h0F, 8'hF0});
    send_pixel('{8'hAA, 8'h55, 8'hF0, 8'h0F});
    send_pixel('{8'h01, 8'h02, 8'h03, 8'h80});
    send_pixel('{8'h80, 8'h40, 8'h20, 8'h01});
    drain();

    // red: -254/255 truncates to 0; green: -255/255 gives -1; blue saturates both ways
    load_rows({16'h0000, 16'h0000, 16'hFF02, 16'h0001},
              {16'h0000, 16'h0000, 16'hFF01, 16'h0001},
              {16'h0000, 16'h8000, 16'h7FFF, 16'h0000}, 1'b1);
    send_pixel('{8'h01, 8'h00, 8'h00, 8'h33});
    send_pixel('{8'h02, 8'h00, 8'h00, 8'hCC});
    send_pixel('{8'hFF, 8'h00, 8'h00, 8'h00});
    send_pixel('{8'h00, 8'hFF, 8'h00, 8'hFF});
    send_pixel('{8'h00, 8'h00, 8'hFF, 8'h5A});
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hA5});
    send_pixel('{8'h00, 8'h00, 8'h00, 8'h7F});
    drain();

    // offsets at both extremes with zero coefficients
    load_rows(64'h0000_0000_0000_7FFF, 64'h0000_0000_0000_8000,
              64'h0000_0000_0000_00FF, 1'b0);
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel('{8'h00, 8'h00, 8'h00, 8'h00});
    drain();

    foreach (kinds[ph]) begin
      load_rows(make_row(kinds[ph]), make_row(kinds[ph]), make_row(kinds[ph]), 1'b0);
      quiet = (ph == 3);
      // long result stall while pixels keep coming, so the input backs up
      if (ph == 6) hold_request = HOLD_CYCLES;
      send_random(PHASE_ITEMS);
      drain();
    end

    if (mcheck.errors == 0) begin
      $display("color_matrix_transform_unit_test: done, clean");
    end else begin
      $display("color_matrix_transform_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("color_matrix_transform_unit_test: done, errors");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/cmt_pkg.sv
sv/cmt_ifs.sv
sv/cmt_channel.sv
sv/color_matrix_transform_unit.sv
test/color_matrix_transform_unit_test.sv
